// ----- src/mld_pkg.sv -----
`default_nettype none

package mld_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [7:0] START_MARKER_RST = 8'h02;
	localparam logic [7:0] END_MARKER_RST = 8'h03;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_MARKER = 1'b0,
		REG_END_MARKER   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] length;
	} result_t;

endpackage

`default_nettype wire

// ----- src/mld_fsm.sv -----
`default_nettype none

module mld_fsm import mld_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [7:0]              cfg_data,
	input  wire logic                    accept,
	input  wire logic [7:0]              in_byte,
	output result_t                      res
);

	localparam int LEN_BYTES = (LENGTH_BITS + 7) / 8;
	localparam logic [LENGTH_BITS-1:0] LEN_BYTES_W = LENGTH_BITS'(LEN_BYTES);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_END
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [LENGTH_BITS-1:0] left_q, left_d;
	logic [7:0]             start_q;
	logic [7:0]             end_q;
	logic [LENGTH_BITS-1:0] pos_diff;
	logic [1:0]             pos;
	logic [LENGTH_BITS-1:0] len_merged;

	assign pos_diff = LEN_BYTES_W - left_q;
	assign pos = pos_diff[1:0];
	assign len_merged = len_q | LENGTH_BITS'(32'(in_byte) << {pos, 3'b000});

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		left_d = left_q;
		res.valid = 1'b0;
		res.kind = KIND_PAYLOAD;
		res.data = '0;
		res.length = 16'(len_q);
		if (accept) begin
			case (phase_q)
				PH_HUNT: begin
					if (in_byte == start_q) begin
						phase_d = PH_LENGTH;
						len_d = '0;
						left_d = LEN_BYTES_W;
					end
				end
				PH_LENGTH: begin
					len_d = len_merged;
					left_d = left_q - 1'b1;
					if (left_q == LENGTH_BITS'(1)) begin
						if (len_merged == '0) begin
							phase_d = PH_END;
						end else begin
							phase_d = PH_PAYLOAD;
							left_d = len_merged;
						end
					end
				end
				PH_PAYLOAD: begin
					res.valid = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.data = in_byte;
					left_d = left_q - 1'b1;
					if (left_q == LENGTH_BITS'(1)) begin
						phase_d = PH_END;
					end
				end
				PH_END: begin
					res.valid = 1'b1;
					res.kind = (in_byte == end_q) ? KIND_GOOD : KIND_BAD;
					phase_d = PH_HUNT;
					left_d = '0;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q <= '0;
			left_q <= '0;
			start_q <= START_MARKER_RST;
			end_q <= END_MARKER_RST;
		end else begin
			phase_q <= phase_d;
			len_q <= len_d;
			left_q <= left_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_START_MARKER: start_q <= cfg_data;
					REG_END_MARKER:   end_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != '0))
		else $error("payload phase with no bytes left");

	a_length_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LENGTH) |-> ((left_q != '0) && (left_q <= LEN_BYTES_W)))
		else $error("length byte count out of range");

endmodule

`default_nettype wire

// ----- src/mld_skid.sv -----
`default_nettype none

module mld_skid import mld_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire result_t push,
	output logic         in_stall,
	input  wire logic    out_stall,
	output result_t      out_res
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push.valid;
			end
		end else if (push.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : push;
		end else if (push.valid) begin
			skid_q <= push;
		end
	end

	always_comb begin
		out_res = out_q;
		out_res.valid = out_valid_q;
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled while output register was free");

endmodule

`default_nettype wire

// ----- src/marker_length_deframer.sv -----
// A result word is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one input word per cycle unless stalled; each byte is decoded combinationally.
// Under output stall the skid register takes one more result word, and the input is then
// stalled until the output register drains.
// Reset (arst_n low, asynchronous): hunting for a start marker, length and count zero,
// markers back to 0x02 and 0x03, output and skid empty.
`default_nettype none

module marker_length_deframer import mld_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [7:0]              cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [7:0]              in_byte,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [1:0]                   kind,
	output logic [7:0]                   out_byte,
	output logic [15:0]                  frame_length
);

	logic    accept;
	result_t fsm_res;
	result_t out_res;

	assign accept = in_valid && !in_stall;

	mld_fsm #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.in_byte  (in_byte),
		.res      (fsm_res)
	);

	mld_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fsm_res),
		.in_stall (in_stall),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign out_valid = out_res.valid;
	assign kind = out_res.kind;
	assign out_byte = out_res.data;
	assign frame_length = out_res.length;

endmodule

`default_nettype wire

// ----- sim/marker_length_deframer_test.sv -----
`timescale 1ns / 100ps

module marker_length_deframer_test import mld_pkg::*;;

	localparam int LEN_BYTES = (LENGTH_BITS_DEF + 7) / 8;
	localparam logic [31:0] LENGTH_MASK = 32'((64'd1 << LENGTH_BITS_DEF) - 64'd1);

	typedef enum logic [1:0] {
		FP_HUNT,
		FP_LENGTH,
		FP_PAYLOAD,
		FP_END
	} frame_phase_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] length;
	} deframed_word_t;

	class deframer_tracker;
		logic [7:0]     start_marker;
		logic [7:0]     end_marker;
		frame_phase_t   phase;
		logic [31:0]    length_value;
		logic [31:0]    bytes_left;
		deframed_word_t expected_words [$];
		int             errors;

		function new();
			start_marker = START_MARKER_RST;
			end_marker = END_MARKER_RST;
			phase = FP_HUNT;
			length_value = '0;
			bytes_left = '0;
			errors = 0;
		endfunction

		function void set_marker(reg_idx_t idx, logic [7:0] value);
			if (idx == REG_START_MARKER) begin
				start_marker = value;
			end else begin
				end_marker = value;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			deframed_word_t w;
			int pos;
			case (phase)
				FP_HUNT: begin
					if (b == start_marker) begin
						phase = FP_LENGTH;
						length_value = '0;
						bytes_left = LEN_BYTES;
					end
				end
				FP_LENGTH: begin
					pos = (LEN_BYTES - int'(bytes_left)) & 3;
					length_value = (length_value | (32'(b) << (8 * pos))) & LENGTH_MASK;
					bytes_left = bytes_left - 1;
					if (bytes_left == 0) begin
						if (length_value == 0) begin
							phase = FP_END;
						end else begin
							phase = FP_PAYLOAD;
							bytes_left = length_value;
						end
					end
				end
				FP_PAYLOAD: begin
					w.kind = KIND_PAYLOAD;
					w.data = b;
					w.length = length_value[15:0];
					expected_words.push_back(w);
					bytes_left = bytes_left - 1;
					if (bytes_left == 0) begin
						phase = FP_END;
					end
				end
				default: begin
					w.kind = (b == end_marker) ? KIND_GOOD : KIND_BAD;
					w.data = '0;
					w.length = length_value[15:0];
					expected_words.push_back(w);
					phase = FP_HUNT;
					bytes_left = '0;
				end
			endcase
		endfunction

		function void check_word(logic [1:0] k, logic [7:0] d, logic [15:0] len);
			deframed_word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d, out_byte 0x%02h, frame_length %0d", k, d, len);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (k !== w.kind) begin
				$error("kind: expected %0d, actual %0d", w.kind, k);
				errors++;
			end
			if (d !== w.data) begin
				$error("out_byte: expected 0x%02h, actual 0x%02h", w.data, d);
				errors++;
			end
			if (len !== w.length) begin
				$error("frame_length: expected %0d, actual %0d", w.length, len);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [7:0]              cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [7:0]              in_byte;
	logic                    out_valid;
	logic                    out_stall;
	logic [1:0]              kind;
	logic [7:0]              out_byte;
	logic [15:0]             frame_length;

	deframer_tracker tracker;
	bit              no_idle;

	marker_length_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.out_byte     (out_byte),
		.frame_length (frame_length)
	);

	function automatic int idle_cycles();
		return no_idle ? 0 : int'($urandom_range(0, 9));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (in_stall);
		tracker.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] len, input bit good_end);
		logic [7:0] b;
		send_byte(tracker.start_marker);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 0; i < int'(len); i++) begin
			case ($urandom_range(0, 19))
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = tracker.start_marker;
				3: b = tracker.end_marker;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
		if (good_end) begin
			b = tracker.end_marker;
		end else begin
			do b = 8'($urandom_range(0, 255)); while (b == tracker.end_marker);
		end
		send_byte(b);
	endtask

	task automatic send_random_stream(input int budget);
		int sent;
		int noise;
		int len;
		logic [7:0] b;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 15) == 0) begin
				no_idle = !no_idle;
			end
			noise = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
			repeat (noise) begin
				do b = 8'($urandom_range(0, 255)); while (b == tracker.start_marker);
				send_byte(b);
			end
			case ($urandom_range(0, 19))
				0: len = $urandom_range(100, 300);
				1, 2, 3, 4, 5: len = $urandom_range(9, 40);
				default: len = $urandom_range(0, 8);
			endcase
			send_frame(16'(len), $urandom_range(0, 6) != 0);
			sent += len + LEN_BYTES + 2;
		end
	endtask

	task automatic drain();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (tracker.expected_words.size() != 0 && n < 5000) begin
			@(negedge clk);
			n++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_marker(input reg_idx_t idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_marker(idx, value);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = idle_cycles();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_word(kind, out_byte, frame_length);
		end
	end

	initial begin
		logic [7:0] opening_bytes [22];
		tracker = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_MARKER;
		cfg_data = '0;
		in_valid = 1'b0;
		in_byte = '0;
		out_stall = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Noise while hunting, an empty frame, a start marker used as length and
		// as payload, a bad end that is itself a start marker, and an empty frame
		// with a bad end.
		opening_bytes = '{8'hFF, 8'h00, 8'h03,
			8'h02, 8'h00, 8'h00, 8'h03,
			8'h02, 8'h02, 8'h00, 8'h00, 8'hFF, 8'h03,
			8'h02, 8'h01, 8'h00, 8'h02, 8'h02,
			8'h02, 8'h00, 8'h00, 8'h07};
		foreach (opening_bytes[i]) begin
			send_byte(opening_bytes[i]);
		end
		send_random_stream(300);
		drain();

		write_marker(REG_START_MARKER, 8'h00);
		write_marker(REG_END_MARKER, 8'hFF);
		send_random_stream(300);
		drain();

		write_marker(REG_START_MARKER, 8'hFF);
		write_marker(REG_END_MARKER, 8'h00);
		send_random_stream(300);
		drain();

		write_marker(REG_START_MARKER, 8'hA5);
		write_marker(REG_END_MARKER, 8'hA5);
		send_random_stream(300);
		drain();

		write_marker(REG_START_MARKER, 8'($urandom_range(0, 255)));
		write_marker(REG_END_MARKER, 8'($urandom_range(0, 255)));
		send_random_stream(300);
		drain();

		if (tracker.expected_words.size() != 0) begin
			$error("%0d expected words never arrived", tracker.expected_words.size());
			tracker.errors++;
		end
		if (tracker.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
